// ===== rtl/core/cfof_pkg.sv =====
// Package for the case-folded one-at-a-time / FNV-1a string hash.
// Constants and the per-byte update and finalization functions.
// No dependencies.
`default_nettype none

package cfof_pkg;

  localparam logic [31:0] FNV_OFFSET_BASIS = 32'h811c_9dc5;
  localparam logic [31:0] FNV_PRIME_32     = 32'h0100_0193;
  localparam logic [31:0] OAT_INIT         = 32'h0000_0000;
  localparam logic [7:0]  ASCII_UPPER_A    = 8'h41;
  localparam logic [7:0]  ASCII_UPPER_Z    = 8'h5a;
  localparam logic [7:0]  ASCII_CASE_BIT   = 8'h20;
  localparam int unsigned HASH_W           = 32;
  localparam int unsigned CHAR_W           = 8;

  // Only ASCII A-Z fold; everything else, including bytes above 0x7f, passes.
  function automatic logic [CHAR_W-1:0] fold_lower(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE_BIT;
    end
    return r;
  endfunction

  function automatic logic [HASH_W-1:0] oat_absorb(input logic [HASH_W-1:0] h_in,
                                                   input logic [CHAR_W-1:0] b);
    logic [HASH_W-1:0] h;
    h = h_in + {{(HASH_W-CHAR_W){1'b0}}, b};
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // Multiply by 0x01000193 as a shift-add: bits 24, 8, 7, 4, 1, 0.
  function automatic logic [HASH_W-1:0] fnv_absorb(input logic [HASH_W-1:0] f_in,
                                                   input logic [CHAR_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = f_in ^ {{(HASH_W-CHAR_W){1'b0}}, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  function automatic logic [HASH_W-1:0] hash_finish(input logic [HASH_W-1:0] oat,
                                                    input logic [HASH_W-1:0] fnv);
    logic [HASH_W-1:0] h;
    h = oat + (oat << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h ^ {fnv[HASH_W-14:0], fnv[HASH_W-1:HASH_W-13]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/case_folded_oat_fnv_hash.sv =====
// Top level of the case-folded one-at-a-time / FNV-1a string hash.
// Depends on cfof_pkg (constants, absorb and finish functions).
// A closing word passes from the input register through the finalize stage to the result register, then out_*.
// Throughput: one word per cycle unless a closing word waits for room downstream; feedback is one absorb step.
// Reset (rst_n low, sync): pipeline empty, oat accum 0, fnv accum = offset basis.
`default_nettype none

module case_folded_oat_fnv_hash (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [cfof_pkg::CHAR_W-1:0]     in_char_code,
  input  wire logic                            in_has_char,
  input  wire logic                            in_last_char,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [cfof_pkg::HASH_W-1:0]          out_hash_value
);
  import cfof_pkg::*;

  // Stage 1: input register holding one word.
  logic                 in_v_r;
  logic [CHAR_W-1:0]    char_r;
  logic                 has_r;
  logic                 last_r;

  // Running accumulators (feedback loop: one absorb per cycle).
  logic [HASH_W-1:0]    oat_r, oat_nxt;
  logic [HASH_W-1:0]    fnv_r, fnv_nxt;

  // Stage 2: absorbed accumulators of a finished string, waiting for finalize.
  logic                 fin_v_r;
  logic [HASH_W-1:0]    fin_oat_r;
  logic [HASH_W-1:0]    fin_fnv_r;

  // Stage 3: result register.
  logic                 out_v_r;
  logic [HASH_W-1:0]    hash_r;

  logic                 fire_in;
  logic                 ends;      // word closes the string (empty marker or last)
  logic                 out_free;  // result register can take a word this cycle
  logic                 fin_free;
  logic                 proc;      // stage 1 word is consumed this cycle
  logic [CHAR_W-1:0]    byte_fold;
  logic [HASH_W-1:0]    oat_mid;
  logic [HASH_W-1:0]    fnv_mid;

  assign out_free = !out_v_r || !out_stall;
  assign fin_free = !fin_v_r || out_free;
  assign ends     = !has_r || last_r;
  // A mid-string character never waits; only closing words need room downstream.
  assign proc     = in_v_r && (!ends || fin_free);
  assign in_stall = in_v_r && !proc;
  assign fire_in  = in_valid && !in_stall;

  assign byte_fold = fold_lower(char_r);
  assign oat_mid   = has_r ? oat_absorb(oat_r, byte_fold) : oat_r;
  assign fnv_mid   = has_r ? fnv_absorb(fnv_r, byte_fold) : fnv_r;

  always_comb begin
    oat_nxt = oat_r;
    fnv_nxt = fnv_r;
    if (proc) begin
      if (ends) begin
        oat_nxt = OAT_INIT;
        fnv_nxt = FNV_OFFSET_BASIS;
      end else begin
        oat_nxt = oat_mid;
        fnv_nxt = fnv_mid;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
      oat_r   <= OAT_INIT;
      fnv_r   <= FNV_OFFSET_BASIS;
    end else begin
      oat_r <= oat_nxt;
      fnv_r <= fnv_nxt;

      if (fire_in) begin
        in_v_r <= 1'b1;
      end else if (proc) begin
        in_v_r <= 1'b0;
      end

      if (proc && ends) begin
        fin_v_r <= 1'b1;
      end else if (out_free) begin
        fin_v_r <= 1'b0;
      end

      if (fin_v_r && out_free) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (fire_in) begin
      char_r <= in_char_code;
      has_r  <= in_has_char;
      last_r <= in_last_char;
    end
    if (proc && ends) begin
      fin_oat_r <= oat_mid;
      fin_fnv_r <= fnv_mid;
    end
    if (fin_v_r && out_free) begin
      hash_r <= hash_finish(fin_oat_r, fin_fnv_r);
    end
  end

  assign out_valid      = out_v_r;
  assign out_hash_value = hash_r;

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty input register");

  a_close_fills_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ends) |=> fin_v_r)
    else $error("closing word did not reach finalize stage");

  a_close_resets_accum: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && ends) |=> (oat_r == OAT_INIT) && (fnv_r == FNV_OFFSET_BASIS))
    else $error("accumulators not reset after string end");

  a_fin_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_v_r && out_free) |=> out_v_r)
    else $error("finalized hash lost");

  a_empty_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (!fin_v_r && !out_v_r) |-> !in_stall)
    else $error("stall with empty downstream");

endmodule

`default_nettype wire
